@@ design/sxl_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the S-expression lexer.
// No dependencies; imported by every module of the block.
package sxl_pkg;

  typedef enum logic [2:0] {
    EV_SYM_BYTE   = 3'd0,
    EV_STR_BYTE   = 3'd1,
    EV_SYM_END    = 3'd2,
    EV_STR_END    = 3'd3,
    EV_LBRACKET   = 3'd4,
    EV_RBRACKET   = 3'd5,
    EV_APOSTROPHE = 3'd6
  } event_e;

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // Result queue slots; keep a power of two, the queue pointers wrap by overflow
  localparam int QueueDepth = 4;

  // Lexer context carried from one item to the next
  typedef struct packed {
    logic in_string;
    logic escape_pending;
    logic in_comment;
    logic symbol_open;
  } lex_state_t;

  // One token event as it leaves the block
  typedef struct packed {
    event_e     ev;
    logic [7:0] content;
    logic       last;
  } token_t;

  // Events produced by one item: up to two, first in order
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } step_out_t;

endpackage

@@ design/sxl_step.sv @@
`timescale 1ns / 1ps
// Per-byte classification: next lexer context and up to two token events.
// Depends on sxl_pkg.
module sxl_step import sxl_pkg::*; (
  input  lex_state_t state_i,
  input  logic [7:0] char_i,
  output lex_state_t state_o,
  output step_out_t  res_o
);

  logic is_white;
  logic is_delim;

  assign is_white = ((char_i >= CH_TAB) && (char_i <= CH_CR)) || (char_i == CH_SPACE);
  assign is_delim = (char_i == CH_LPAREN) || (char_i == CH_RPAREN) || (char_i == CH_APOS) ||
                    (char_i == CH_SEMI) || (char_i == CH_QUOTE) || is_white;

  always_comb begin
    token_t     own;
    logic       has_own;
    state_o = state_i;
    res_o   = '0;
    own     = '0;
    has_own = 1'b0;

    if (state_i.in_string) begin
      if (state_i.escape_pending) begin
        state_o.escape_pending = 1'b0;
        res_o.count = 2'd1;
        res_o.first = '{ev: EV_STR_BYTE, content: char_i, last: 1'b1};
      end else if (char_i == CH_BSLASH) begin
        state_o.escape_pending = 1'b1;
      end else if (char_i == CH_QUOTE) begin
        state_o.in_string = 1'b0;
        res_o.count = 2'd1;
        res_o.first = '{ev: EV_STR_END, content: 8'h00, last: 1'b1};
      end else begin
        res_o.count = 2'd1;
        res_o.first = '{ev: EV_STR_BYTE, content: char_i, last: 1'b1};
      end
    end else if (state_i.in_comment) begin
      if (char_i == CH_NEWLINE) begin
        state_o.in_comment = 1'b0;
      end
    end else if (is_delim) begin
      if (char_i == CH_LPAREN) begin
        has_own = 1'b1;
        own = '{ev: EV_LBRACKET, content: 8'h00, last: 1'b1};
      end else if (char_i == CH_RPAREN) begin
        has_own = 1'b1;
        own = '{ev: EV_RBRACKET, content: 8'h00, last: 1'b1};
      end else if (char_i == CH_APOS) begin
        has_own = 1'b1;
        own = '{ev: EV_APOSTROPHE, content: 8'h00, last: 1'b1};
      end else if (char_i == CH_SEMI) begin
        state_o.in_comment = 1'b1;
      end else if (char_i == CH_QUOTE) begin
        state_o.in_string      = 1'b1;
        state_o.escape_pending = 1'b0;
      end
      // close an open symbol ahead of the delimiter's own event
      if (state_i.symbol_open) begin
        state_o.symbol_open = 1'b0;
        res_o.first = '{ev: EV_SYM_END, content: 8'h00, last: !has_own};
        res_o.second = own;
        res_o.count = has_own ? 2'd2 : 2'd1;
      end else begin
        res_o.first = own;
        res_o.count = has_own ? 2'd1 : 2'd0;
      end
    end else begin
      state_o.symbol_open = 1'b1;
      res_o.count = 2'd1;
      res_o.first = '{ev: EV_SYM_BYTE, content: char_i, last: 1'b1};
    end
  end

endmodule

@@ design/sxl_fifo.sv @@
`timescale 1ns / 1ps
// Result queue: takes up to two token events per cycle, hands out one each cycle it is popped.
// Depends on sxl_pkg.
module sxl_fifo import sxl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  step_out_t push_i,
  input  logic      push_en_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      pop_i,
  output token_t    head_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  token_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   n_push;
  logic              do_pop;
  logic [PtrW-1:0]   wr_next;

  assign do_pop  = pop_i && valid_o;
  assign n_push  = push_en_i ? CntW'(push_i.count) : '0;
  assign wr_next = wr_ptr_q + PtrW'(1);
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  // hold off new items until two slots are free
  assign room_o  = (count_q <= CntW'(QueueDepth - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(n_push);
    rd_ptr_d = rd_ptr_q + PtrW'(do_pop);
    count_d  = count_q + n_push - CntW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_en_i && (push_i.count != 2'd0)) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_en_i && (push_i.count == 2'd2)) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ design/sexpr_lexer.sv @@
`timescale 1ns / 1ps
// S-expression lexer: turns a byte stream into token events, one byte per cycle unless stalled.
// Top level; depends on sxl_pkg, sxl_step and sxl_fifo.
//
// Each accepted text byte lands in an input register; from there the byte is classified
// against the lexer context (string, escape, comment, open symbol) and, once the queue has
// two free slots, its zero, one or two token events enter a small result queue, from which
// events leave one per cycle while the output is not stalled. A byte's events pass through
// the input register and the result queue before they reach the output. The block takes a
// new byte every cycle while the queue has two free slots. A byte yields two events only
// when a bracket or apostrophe closes a symbol, so the sustained rate is one byte per cycle
// unless the output side is stalled or such closing pairs come faster than the queue drains.
// Symbol and string contents stream out byte by byte; last marks the final event of each
// input byte.
module sexpr_lexer import sxl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic [7:0] content_byte_o,
  output logic       last_o
);

  logic       item_valid_q, item_valid_d;
  logic [7:0] char_q;
  lex_state_t state_q, state_d;
  step_out_t  step_res;
  logic       room;
  logic       fire;
  logic       accept;
  token_t     head;

  sxl_step u_step (
    .state_i (state_q),
    .char_i  (char_q),
    .state_o (state_d),
    .res_o   (step_res)
  );

  sxl_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (step_res),
    .push_en_i (fire),
    .room_o    (room),
    .valid_o   (out_valid_o),
    .pop_i     (!out_stall_i),
    .head_o    (head)
  );

  assign fire         = item_valid_q && room;
  assign in_stall_o   = item_valid_q && !room;
  assign accept       = in_valid_i && !in_stall_o;
  assign item_valid_d = accept || (item_valid_q && !fire);

  assign event_res_o    = head.ev;
  assign content_byte_o = head.content;
  assign last_o         = head.last;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      state_q      <= '0;
    end else begin
      item_valid_q <= item_valid_d;
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

endmodule

@@ sim/sexpr_lexer_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for sexpr_lexer: directed byte table, then line-shaped random text.
// Depends on sxl_pkg and the sexpr_lexer RTL; predicts token events with its own lexer.
module sexpr_lexer_test;
  import sxl_pkg::*;

  localparam int DrainCycles = 24;
  localparam int HoldCycles  = 200;
  localparam int NumRows     = 25;

  typedef struct {
    logic [7:0] ch;
    int         n;     // typed event count, -1 where the predictor decides
    event_e     ev0;
    logic [7:0] b0;
    event_e     ev1;
  } stim_row_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] char_in_i   = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [2:0] event_res_o;
  logic [7:0] content_byte_o;
  logic       last_o;

  lex_state_t lex_ctx = '0;
  token_t     pending_tokens [$];
  int         fail_count   = 0;
  int         items_sent   = 0;
  int         snd_idle_pct = 0;
  int         rcv_idle_pct = 0;
  int         hold_left    = 0;

  // Extremes, every event, then the string, escape and comment corners
  stim_row_t dir_rows [NumRows] = '{
    '{8'h61, 1, EV_SYM_BYTE, 8'h61, EV_SYM_BYTE},
    '{8'h00, 1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{8'hFF, 1, EV_SYM_BYTE, 8'hFF, EV_SYM_BYTE},
    '{CH_LPAREN, 2, EV_SYM_END, 8'h00, EV_LBRACKET},
    '{CH_RPAREN, 1, EV_RBRACKET, 8'h00, EV_SYM_BYTE},
    '{CH_APOS, 1, EV_APOSTROPHE, 8'h00, EV_SYM_BYTE},
    '{CH_TAB, 0, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{8'h78, 1, EV_SYM_BYTE, 8'h78, EV_SYM_BYTE},
    '{CH_CR, 1, EV_SYM_END, 8'h00, EV_SYM_BYTE},
    '{CH_QUOTE, 0, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_QUOTE, 1, EV_STR_END, 8'h00, EV_SYM_BYTE},
    '{8'h79, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_QUOTE, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_BSLASH, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_QUOTE, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_BSLASH, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_BSLASH, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{8'h80, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_NEWLINE, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_QUOTE, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{8'h7A, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_SEMI, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_LPAREN, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_NEWLINE, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE},
    '{CH_SPACE, -1, EV_SYM_BYTE, 8'h00, EV_SYM_BYTE}
  };

  sexpr_lexer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_in_i      (char_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .content_byte_o (content_byte_o),
    .last_o         (last_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit is_space(logic [7:0] c);
    return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
  endfunction

  function automatic bit is_delim(logic [7:0] c);
    return c == CH_LPAREN || c == CH_RPAREN || c == CH_APOS || c == CH_SEMI ||
           c == CH_QUOTE || is_space(c);
  endfunction

  // Advance the lexer context by one byte; return the events it yields
  function automatic int lex_predict(input logic [7:0] c, output token_t t0,
                                     output token_t t1);
    token_t evs [2];
    int     n;
    n      = 0;
    evs[0] = '0;
    evs[1] = '0;
    if (lex_ctx.in_string) begin
      if (lex_ctx.escape_pending) begin
        lex_ctx.escape_pending = 1'b0;
        evs[n] = '{EV_STR_BYTE, c, 1'b0};
        n = n + 1;
      end else if (c == CH_BSLASH) begin
        lex_ctx.escape_pending = 1'b1;
      end else if (c == CH_QUOTE) begin
        lex_ctx.in_string = 1'b0;
        evs[n] = '{EV_STR_END, 8'h00, 1'b0};
        n = n + 1;
      end else begin
        evs[n] = '{EV_STR_BYTE, c, 1'b0};
        n = n + 1;
      end
    end else if (lex_ctx.in_comment) begin
      if (c == CH_NEWLINE) lex_ctx.in_comment = 1'b0;
    end else if (is_delim(c)) begin
      if (lex_ctx.symbol_open) begin
        lex_ctx.symbol_open = 1'b0;
        evs[n] = '{EV_SYM_END, 8'h00, 1'b0};
        n = n + 1;
      end
      case (c)
        CH_LPAREN: begin
          evs[n] = '{EV_LBRACKET, 8'h00, 1'b0};
          n = n + 1;
        end
        CH_RPAREN: begin
          evs[n] = '{EV_RBRACKET, 8'h00, 1'b0};
          n = n + 1;
        end
        CH_APOS: begin
          evs[n] = '{EV_APOSTROPHE, 8'h00, 1'b0};
          n = n + 1;
        end
        CH_SEMI:   lex_ctx.in_comment = 1'b1;
        CH_QUOTE: begin
          lex_ctx.in_string      = 1'b1;
          lex_ctx.escape_pending = 1'b0;
        end
        default: ;
      endcase
    end else begin
      lex_ctx.symbol_open = 1'b1;
      evs[n] = '{EV_SYM_BYTE, c, 1'b0};
      n = n + 1;
    end
    if (n > 0) evs[n-1].last = 1'b1;
    t0 = evs[0];
    t1 = evs[1];
    return n;
  endfunction

  // Offer one byte from a falling edge; on acceptance queue its events
  task automatic send_char(input logic [7:0] c, input int typed_n = -1,
                           input token_t typed0 = '0, input token_t typed1 = '0);
    token_t t0, t1;
    int     n;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    char_in_i  = c;
    do @(posedge clk_i); while (in_stall_o);
    n = lex_predict(c, t0, t1);
    if (typed_n >= 0) begin
      n  = typed_n;
      t0 = typed0;
      t1 = typed1;
    end
    if (n > 0) pending_tokens = {pending_tokens, t0};
    if (n > 1) pending_tokens = {pending_tokens, t1};
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Change idling off the falling edge so the receiver process sees it cleanly
  task automatic start_phase(input int snd_pct, input int rcv_pct, input int hold);
    @(posedge clk_i);
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    hold_left    = hold;
    @(negedge clk_i);
  endtask

  // One text line: symbols, strings, brackets, whitespace, comments, a little noise, newline
  task automatic emit_line();
    int         ntok, kind, len;
    logic [7:0] b;
    ntok = $urandom_range(8, 1);
    for (int k = 0; k < ntok; k++) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        len = $urandom_range(6, 1);
        for (int j = 0; j < len; j++) begin
          do b = 8'($urandom_range(255)); while (is_delim(b));
          send_char(b);
        end
      end else if (kind < 50) begin
        send_char(CH_QUOTE);
        len = $urandom_range(5, 0);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(99) < 20) begin
            send_char(CH_BSLASH);
            send_char(8'($urandom_range(255)));
          end else begin
            do b = 8'($urandom_range(255)); while (b == CH_QUOTE || b == CH_BSLASH);
            send_char(b);
          end
        end
        send_char(CH_QUOTE);
      end else if (kind < 65) begin
        case ($urandom_range(2))
          0:       send_char(CH_LPAREN);
          1:       send_char(CH_RPAREN);
          default: send_char(CH_APOS);
        endcase
      end else if (kind < 80) begin
        send_char($urandom_range(5) == 5 ? CH_SPACE : CH_TAB + 8'($urandom_range(4)));
      end else if (kind < 88) begin
        send_char(CH_SEMI);
        len = $urandom_range(5, 0);
        for (int j = 0; j < len; j++) begin
          do b = 8'($urandom_range(255)); while (b == CH_NEWLINE);
          send_char(b);
        end
        send_char(CH_NEWLINE);
      end else begin
        send_char(8'($urandom_range(255)));
      end
    end
    send_char(CH_NEWLINE);
  endtask

  // Receiver: a counted hold-off wins over the random stall
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected event %0d content %h last %b", event_res_o, content_byte_o, last_o);
        fail_count++;
      end else begin
        want = pending_tokens.pop_front();
        if (event_res_o !== want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, event_res_o);
          fail_count++;
        end
        if (content_byte_o !== want.content) begin
          $error("content_byte: expected %h, got %h", want.content, content_byte_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("sexpr_lexer: mismatch");
    $finish;
  end

  initial begin
    stim_row_t r;
    token_t    t0, t1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    start_phase(16, 87, 0);
    for (int i = 0; i < NumRows; i++) begin
      r  = dir_rows[i];
      t0 = '{r.ev0, r.b0, r.n == 1};
      t1 = '{r.ev1, 8'h00, 1'b1};
      send_char(r.ch, r.n, t0, t1);
    end
    while (items_sent < 240) emit_line();
    drain();
    start_phase(87, 16, 0);
    while (items_sent < 450) emit_line();
    drain();
    // Hold the output long enough for the block to back up into its input
    start_phase(0, 0, HoldCycles);
    while (items_sent < 650) emit_line();
    drain();
    if (fail_count == 0 && pending_tokens.size() == 0) begin
      $display("sexpr_lexer: match");
    end else begin
      $display("sexpr_lexer: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/sxl_pkg.sv
design/sxl_step.sv
design/sxl_fifo.sv
design/sexpr_lexer.sv
sim/sexpr_lexer_test.sv
